// ===== rtl/timed_actuator_position_controller_top_defines.svh =====
// Assertion helpers shared by the controller RTL.
`ifndef TIMED_ACTUATOR_POSITION_CONTROLLER_TOP_DEFINES_SVH
`define TIMED_ACTUATOR_POSITION_CONTROLLER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TAPC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tapc assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TAPC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tapc assertion failed");

`endif

// ===== rtl/tapc_pkg.sv =====
`default_nettype none

package tapc_pkg;

    localparam int POS_W      = 16;
    localparam int SPEED_W    = 8;
    localparam int DUTY_OUT_W = 8;
    localparam int OP_W       = 3;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam int DUTY_BITS_DEFAULT = 8;

    localparam logic [POS_W-1:0] FULL_TRAVEL_RESET = 16'd3000;

    // Command codes; tick and every unused code share the default behavior.
    localparam logic [OP_W-1:0] OP_EXTEND  = 3'd1;
    localparam logic [OP_W-1:0] OP_RETRACT = 3'd2;
    localparam logic [OP_W-1:0] OP_STOP    = 3'd3;
    localparam logic [OP_W-1:0] OP_SETPOS  = 3'd4;

    // Register index of full_travel_ms.
    localparam logic [0:0] REG_FULL_TRAVEL = 1'b0;

    typedef enum logic [1:0] {
        MOTION_IDLE    = 2'd0,
        MOTION_EXTEND  = 2'd1,
        MOTION_RETRACT = 2'd2
    } t_motion;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [POS_W-1:0]   elapsed_ms;
        logic               at_limit;
        logic [SPEED_W-1:0] speed;
        logic [POS_W-1:0]   new_position;
    } t_in;

    typedef struct packed {
        logic [DUTY_OUT_W-1:0] extend_duty;
        logic [DUTY_OUT_W-1:0] retract_duty;
        logic [1:0]            motion;
        logic [POS_W-1:0]      position_ms;
        logic                  applied;
    } t_out;

endpackage

`default_nettype wire

// ===== rtl/tapc_cfg.sv =====
`default_nettype none

module tapc_cfg
    import tapc_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [POS_W-1:0]      o_full_travel
);

    logic [POS_W-1:0] r_full_travel;
    logic [POS_W-1:0] n_full_travel;
    logic             w_sel_travel;

    // Registers sit on 32-bit words; bit 2 of the byte address is the index.
    assign w_sel_travel = (paddr[2] == REG_FULL_TRAVEL);

    always_comb begin
        n_full_travel = r_full_travel;
        if (psel && penable && pwrite && w_sel_travel) begin
            n_full_travel = pwdata[POS_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full_travel <= FULL_TRAVEL_RESET;
        end else begin
            r_full_travel <= n_full_travel;
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_travel) begin
            prdata = APB_DATA_W'(r_full_travel);
        end
    end

    assign pready        = 1'b1;
    assign o_full_travel = r_full_travel;

endmodule

`default_nettype wire

// ===== rtl/tapc_core.sv =====
`default_nettype none
`include "timed_actuator_position_controller_top_defines.svh"

module tapc_core
    import tapc_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEFAULT
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_fire,
    input  wire t_in              i_item,
    input  wire logic [POS_W-1:0] i_full_travel,
    output t_out                  o_result
);

    localparam int DRV_W = (DUTY_BITS < SPEED_W) ? DUTY_BITS : SPEED_W;

    t_motion          r_motion, n_motion;
    logic [POS_W-1:0] r_pos, n_pos;
    logic             r_applied, n_applied;
    logic [DRV_W-1:0] r_ext_drv, n_ext_drv;
    logic [DRV_W-1:0] r_ret_drv, n_ret_drv;

    logic [POS_W:0]   w_sum;
    logic [POS_W-1:0] w_adv_pos;
    logic [DRV_W-1:0] w_speed;

    assign w_speed = i_item.speed[DRV_W-1:0];
    assign w_sum   = {1'b0, r_pos} + {1'b0, i_item.elapsed_ms};

    // Integrate the elapsed time in the current direction before the command.
    always_comb begin
        case (r_motion)
            MOTION_EXTEND: begin
                w_adv_pos = (w_sum >= {1'b0, i_full_travel}) ? i_full_travel
                                                             : w_sum[POS_W-1:0];
            end
            MOTION_RETRACT: begin
                w_adv_pos = (i_item.elapsed_ms >= r_pos) ? '0
                                                         : r_pos - i_item.elapsed_ms;
            end
            default: begin
                w_adv_pos = r_pos;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_motion  = r_motion;
        n_pos     = w_adv_pos;
        n_applied = r_applied;
        n_ext_drv = r_ext_drv;
        n_ret_drv = r_ret_drv;
        case (i_item.op)
            OP_EXTEND: begin
                n_applied = 1'b1;
                if (i_item.at_limit) begin
                    n_pos     = i_full_travel;
                    n_motion  = MOTION_IDLE;
                    n_ext_drv = '0;
                    n_ret_drv = '0;
                end else if (w_adv_pos >= i_full_travel) begin
                    n_motion  = MOTION_IDLE;
                    n_ext_drv = '0;
                    n_ret_drv = '0;
                end else if (r_motion != MOTION_EXTEND) begin
                    n_motion  = MOTION_EXTEND;
                    n_ext_drv = w_speed;
                    n_ret_drv = '0;
                end
            end
            OP_RETRACT: begin
                n_applied = 1'b0;
                if (r_motion != MOTION_RETRACT) begin
                    n_motion  = MOTION_RETRACT;
                    n_ext_drv = '0;
                    n_ret_drv = w_speed;
                end
            end
            OP_STOP: begin
                n_motion  = MOTION_IDLE;
                n_ext_drv = '0;
                n_ret_drv = '0;
            end
            OP_SETPOS: begin
                n_pos = (i_item.new_position > i_full_travel) ? i_full_travel
                                                              : i_item.new_position;
            end
            default: begin
                // Tick and unused codes: check the end stops of the current travel.
                if (r_motion == MOTION_EXTEND) begin
                    if (i_item.at_limit) begin
                        n_pos     = i_full_travel;
                        n_motion  = MOTION_IDLE;
                        n_ext_drv = '0;
                        n_ret_drv = '0;
                    end else if (w_adv_pos >= i_full_travel) begin
                        n_motion  = MOTION_IDLE;
                        n_ext_drv = '0;
                        n_ret_drv = '0;
                    end
                end else if (r_motion == MOTION_RETRACT) begin
                    if (w_adv_pos == '0) begin
                        n_motion  = MOTION_IDLE;
                        n_ext_drv = '0;
                        n_ret_drv = '0;
                    end
                end
            end
        endcase
    end

    // The result reports the state as it stands after the item.
    always_comb begin
        o_result.extend_duty  = DUTY_OUT_W'(n_ext_drv);
        o_result.retract_duty = DUTY_OUT_W'(n_ret_drv);
        o_result.motion       = n_motion;
        o_result.position_ms  = n_pos;
        o_result.applied      = n_applied && (n_pos != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_motion  <= MOTION_IDLE;
            r_pos     <= '0;
            r_applied <= 1'b0;
            r_ext_drv <= '0;
            r_ret_drv <= '0;
        end else if (i_fire) begin
            r_motion  <= n_motion;
            r_pos     <= n_pos;
            r_applied <= n_applied;
            r_ext_drv <= n_ext_drv;
            r_ret_drv <= n_ret_drv;
        end
    end

    `TAPC_ASSERT_IMPL(a_idle_no_drive, i_clk, i_rst_n, r_motion == MOTION_IDLE, r_ext_drv == '0 && r_ret_drv == '0)
    `TAPC_ASSERT_IMPL(a_extend_no_retract, i_clk, i_rst_n, r_motion == MOTION_EXTEND, r_ret_drv == '0)
    `TAPC_ASSERT_IMPL(a_retract_no_extend, i_clk, i_rst_n, r_motion == MOTION_RETRACT, r_ext_drv == '0)
    `TAPC_ASSERT_NEXT(a_pos_holds_idle, i_clk, i_rst_n, !i_fire, $stable(r_pos) && $stable(r_motion))

endmodule

`default_nettype wire

// ===== rtl/timed_actuator_position_controller_top.sv =====
// Sensorless linear actuator controller. Every command transfer yields exactly one
// result transfer that reports the drive duties, motion, estimated position and the
// applied flag as they stand after the command. The block takes one item per clock
// cycle unless o_in_stall is high; an accepted item waits in the input register,
// and the state update loads the result register from it once the result register
// can take it. A held result stalls the input side once the input register is also
// full. full_travel_ms is written over the APB port at byte address 0 and should
// only change while idle.
`default_nettype none
`include "timed_actuator_position_controller_top_defines.svh"

module timed_actuator_position_controller_top
    import tapc_pkg::*;
#(
    parameter int DUTY_BITS = DUTY_BITS_DEFAULT
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in                   i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out                       o_out_item,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic             r_in_valid;
    t_in              r_in;
    logic             r_out_valid;
    t_out             r_out;
    logic             w_fire;
    logic             w_accept;
    t_out             w_result;
    logic [POS_W-1:0] w_full_travel;

    tapc_cfg u_cfg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_full_travel (w_full_travel)
    );

    tapc_core #(
        .DUTY_BITS (DUTY_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_item        (r_in),
        .i_full_travel (w_full_travel),
        .o_result      (w_result)
    );

    // The held item is processed whenever the result register can take it.
    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= w_accept || (r_in_valid && !w_fire);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    `TAPC_ASSERT_NEXT(a_fire_fills_out, i_clk, i_rst_n, w_fire, r_out_valid)
    `TAPC_ASSERT_NEXT(a_held_item_kept, i_clk, i_rst_n, r_in_valid && !w_fire, r_in_valid && $stable(r_in))
    `TAPC_ASSERT_IMPL(a_no_fire_when_blocked, i_clk, i_rst_n, r_out_valid && i_out_stall, !w_fire)

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`default_nettype none

module tb_top;
    import tapc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [OP_W-1:0] OP_TICK         = 3'd0;
    localparam logic [OP_W-1:0] OP_UNUSED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_LAST  = 3'd7;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PRINT_LIMIT  = 40;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    t_in                   i_in_item = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    t_out                  o_out_item;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    timed_actuator_position_controller_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Predicted controller state, kept in step with the block.
    logic [POS_W-1:0]      travel_ms = FULL_TRAVEL_RESET;
    t_motion               est_motion = MOTION_IDLE;
    logic [POS_W-1:0]      est_position = '0;
    logic                  applied_state = 1'b0;
    logic [DUTY_OUT_W-1:0] ext_drive = '0;
    logic [DUTY_OUT_W-1:0] ret_drive = '0;

    t_in  cmd_q[$];
    t_out status_expected_q[$];
    int   cmds_outstanding = 0;
    int   cmds_accepted = 0;
    int   status_checked = 0;
    int   mismatch_count = 0;
    int   travel_settings = 1;
    int   cycle_count = 0;
    int   sender_idle_pct = 0;
    int   recv_stall_pct = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic void halt_drives();
        ext_drive = '0;
        ret_drive = '0;
        est_motion = MOTION_IDLE;
    endfunction

    // Advances the position estimate by the elapsed time, applies the command and
    // returns the status the block should report afterwards.
    function automatic t_out step_controller(t_in c);
        logic [POS_W:0] sum;
        t_out r;
        if (est_motion == MOTION_EXTEND) begin
            sum = {1'b0, est_position} + {1'b0, c.elapsed_ms};
            est_position = (sum >= {1'b0, travel_ms}) ? travel_ms : sum[POS_W-1:0];
        end else if (est_motion == MOTION_RETRACT) begin
            est_position = (c.elapsed_ms >= est_position) ? '0
                                                          : est_position - c.elapsed_ms;
        end
        case (c.op)
            OP_EXTEND: begin
                applied_state = 1'b1;
                if (c.at_limit) begin
                    est_position = travel_ms;
                    halt_drives();
                end else if (est_position >= travel_ms) begin
                    halt_drives();
                end else if (est_motion != MOTION_EXTEND) begin
                    ret_drive = '0;
                    ext_drive = c.speed;
                    est_motion = MOTION_EXTEND;
                end
            end
            OP_RETRACT: begin
                applied_state = 1'b0;
                if (est_motion != MOTION_RETRACT) begin
                    ext_drive = '0;
                    ret_drive = c.speed;
                    est_motion = MOTION_RETRACT;
                end
            end
            OP_STOP: halt_drives();
            OP_SETPOS: begin
                est_position = (c.new_position > travel_ms) ? travel_ms : c.new_position;
            end
            default: begin
                if (est_motion == MOTION_EXTEND) begin
                    if (c.at_limit) begin
                        est_position = travel_ms;
                        halt_drives();
                    end else if (est_position >= travel_ms) begin
                        halt_drives();
                    end
                end else if (est_motion == MOTION_RETRACT) begin
                    if (est_position == '0) halt_drives();
                end
            end
        endcase
        r.extend_duty  = ext_drive;
        r.retract_duty = ret_drive;
        r.motion       = est_motion;
        r.position_ms  = est_position;
        r.applied      = applied_state && (est_position != '0);
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    function automatic t_in make_cmd(logic [OP_W-1:0] op, int unsigned dt, bit lim,
                                     int unsigned spd, int unsigned np);
        t_in c;
        c.op           = op;
        c.elapsed_ms   = dt[POS_W-1:0];
        c.at_limit     = lim;
        c.speed        = spd[SPEED_W-1:0];
        c.new_position = np[POS_W-1:0];
        return c;
    endfunction

    // Mostly realistic motion: short time steps against the travel, occasional
    // limit closures, plus full-range values and the unused command codes.
    function automatic t_in random_cmd();
        t_in c;
        int unsigned pick;
        int unsigned step_max;
        step_max = travel_ms / 8 + 1;
        pick = $urandom_range(99);
        if (pick < 35)      c.op = OP_TICK;
        else if (pick < 50) c.op = OP_EXTEND;
        else if (pick < 65) c.op = OP_RETRACT;
        else if (pick < 75) c.op = OP_STOP;
        else if (pick < 90) c.op = OP_SETPOS;
        else                c.op = OP_W'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
        pick = $urandom_range(99);
        if (pick < 10)      c.elapsed_ms = '0;
        else if (pick < 60) c.elapsed_ms = POS_W'($urandom_range(step_max, 0));
        else if (pick < 90) c.elapsed_ms = POS_W'($urandom_range(16'hFFFF, 0));
        else                c.elapsed_ms = '1;
        c.at_limit = ($urandom_range(99) < 8);
        c.speed = SPEED_W'($urandom_range(255, 0));
        if ($urandom_range(1) == 0) c.new_position = POS_W'($urandom_range(travel_ms, 0));
        else                        c.new_position = POS_W'($urandom_range(16'hFFFF, 0));
        return c;
    endfunction

    task automatic queue_cmd(t_in c);
        cmd_q.push_back(c);
        cmds_outstanding++;
    endtask

    task automatic queue_random(int count);
        repeat (count) queue_cmd(random_cmd());
    endtask

    task automatic wait_drained();
        while (cmds_outstanding != 0 || status_expected_q.size() != 0) @(posedge i_clk);
    endtask

    // Writes the travel register, then reads it back with psel held through both.
    task automatic write_full_travel(logic [POS_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(REG_FULL_TRAVEL) << 2;
        pwdata  <= {16'($urandom_range(16'hFFFF, 0)), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        travel_ms = value;
        travel_settings++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[POS_W-1:0] !== value)
            report_mismatch("full_travel_ms read back", 32'(prdata[POS_W-1:0]), 32'(value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Command driver: a new transfer is offered once the previous one is taken.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                status_expected_q.push_back(step_controller(i_in_item));
                cmds_outstanding--;
                cmds_accepted++;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (cmd_q.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
                    i_in_item  <= cmd_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Status monitor and receiver stall.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (status_expected_q.size() == 0) begin
                    report_mismatch("unexpected status transfer", 32'(o_out_item), 32'd0);
                end else begin
                    want = status_expected_q.pop_front();
                    status_checked++;
                    if (o_out_item.extend_duty !== want.extend_duty)
                        report_mismatch("extend_duty", 32'(o_out_item.extend_duty),
                                        32'(want.extend_duty));
                    if (o_out_item.retract_duty !== want.retract_duty)
                        report_mismatch("retract_duty", 32'(o_out_item.retract_duty),
                                        32'(want.retract_duty));
                    if (o_out_item.motion !== want.motion)
                        report_mismatch("motion", 32'(o_out_item.motion), 32'(want.motion));
                    if (o_out_item.position_ms !== want.position_ms)
                        report_mismatch("position_ms", 32'(o_out_item.position_ms),
                                        32'(want.position_ms));
                    if (o_out_item.applied !== want.applied)
                        report_mismatch("applied", 32'(o_out_item.applied), 32'(want.applied));
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timed out with %0d commands and %0d results still pending.",
                     cmds_outstanding, status_expected_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset travel, no idling: walk through every command and corner.
        queue_cmd(make_cmd(OP_TICK, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_EXTEND, 0, 0, 255, 0));
        queue_cmd(make_cmd(OP_TICK, 1000, 0, 0, 0));
        queue_cmd(make_cmd(OP_EXTEND, 500, 0, 17, 0));
        queue_cmd(make_cmd(OP_TICK, 16'hFFFF, 0, 0, 0));
        queue_cmd(make_cmd(OP_EXTEND, 0, 0, 40, 0));
        queue_cmd(make_cmd(OP_RETRACT, 0, 0, 128, 0));
        queue_cmd(make_cmd(OP_RETRACT, 1000, 0, 3, 0));
        queue_cmd(make_cmd(OP_TICK, 16'hFFFF, 0, 0, 0));
        queue_cmd(make_cmd(OP_RETRACT, 7, 0, 1, 0));
        queue_cmd(make_cmd(OP_TICK, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_EXTEND, 0, 1, 200, 0));
        queue_cmd(make_cmd(OP_SETPOS, 0, 0, 0, 16'hFFFF));
        queue_cmd(make_cmd(OP_SETPOS, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_EXTEND, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_TICK, 10, 1, 0, 0));
        queue_cmd(make_cmd(OP_SETPOS, 0, 1, 255, 1234));
        queue_cmd(make_cmd(OP_RETRACT, 0, 0, 200, 0));
        queue_cmd(make_cmd(OP_UNUSED_FIRST, 100, 0, 0, 0));
        queue_cmd(make_cmd(OP_UNUSED_FIRST + 3'd1, 100, 1, 0, 0));
        queue_cmd(make_cmd(OP_UNUSED_LAST, 16'hFFFF, 0, 0, 0));
        queue_cmd(make_cmd(OP_EXTEND, 0, 0, 90, 0));
        queue_cmd(make_cmd(OP_SETPOS, 50, 0, 0, 100));
        queue_cmd(make_cmd(OP_STOP, 20, 0, 0, 0));
        queue_cmd(make_cmd(OP_TICK, 500, 0, 0, 0));
        queue_random(80);
        wait_drained();

        // Longest travel, sender mostly idle. Park far out for the next phase.
        write_full_travel(16'hFFFF);
        sender_idle_pct = 72;
        queue_random(110);
        queue_cmd(make_cmd(OP_STOP, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_SETPOS, 0, 0, 0, 60000));
        wait_drained();

        // Travel shortened below the parked position, receiver mostly stalling.
        write_full_travel(16'd1);
        sender_idle_pct = 0;
        recv_stall_pct = 72;
        queue_cmd(make_cmd(OP_TICK, 5, 0, 0, 0));
        queue_cmd(make_cmd(OP_EXTEND, 0, 0, 50, 0));
        queue_cmd(make_cmd(OP_RETRACT, 0, 0, 60, 0));
        queue_cmd(make_cmd(OP_TICK, 100, 0, 0, 0));
        queue_cmd(make_cmd(OP_STOP, 0, 0, 0, 0));
        queue_cmd(make_cmd(OP_SETPOS, 0, 0, 0, 16'hFFFF));
        queue_random(110);
        wait_drained();

        // Zero travel: extending ends at once.
        write_full_travel(16'd0);
        sender_idle_pct = 30;
        recv_stall_pct = 30;
        queue_cmd(make_cmd(OP_EXTEND, 0, 0, 9, 0));
        queue_cmd(make_cmd(OP_RETRACT, 0, 0, 9, 0));
        queue_cmd(make_cmd(OP_TICK, 3, 0, 0, 0));
        queue_cmd(make_cmd(OP_SETPOS, 0, 0, 0, 500));
        queue_random(110);
        wait_drained();

        write_full_travel(POS_W'($urandom_range(5000, 2)));
        sender_idle_pct = 0;
        recv_stall_pct = 0;
        queue_random(110);
        wait_drained();

        write_full_travel(FULL_TRAVEL_RESET);
        sender_idle_pct = 30;
        recv_stall_pct = 30;
        queue_random(110);
        wait_drained();

        repeat (5) @(posedge i_clk);
        $display("Sent %0d commands and checked %0d status transfers across %0d travel settings,",
                 cmds_accepted, status_checked, travel_settings);
        $display("with %0d mismatches under four idle and stall mixes.", mismatch_count);
        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire
